FILE: design/qemi_pkg.sv
// ----------------------------------------------------------------------------
// qemi_pkg
// Shared constants and helpers for the exponential-map orientation integrator.
// ----------------------------------------------------------------------------
package qemi_pkg;

   localparam int COMP_W       = 32;
   localparam int DVD_W        = 62;
   localparam int DSR_W        = 32;
   localparam int DIV_CNT_W    = $clog2(DVD_W);
   localparam int CORDIC_ITERATIONS = 24;
   localparam int CORDIC_STEPS = (CORDIC_ITERATIONS < 32) ? CORDIC_ITERATIONS : 32;

   localparam logic [33:0] ONE_Q30         = 34'sd1073741824;
   localparam logic [63:0] SMALL_ANGLE_LIM = 64'd11529215047;

   localparam logic [1:0] CSR_QW = 2'd0;
   localparam logic [1:0] CSR_QX = 2'd1;
   localparam logic [1:0] CSR_QY = 2'd2;
   localparam logic [1:0] CSR_QZ = 2'd3;

   // atan(2^-i) in Q.30, truncated
   function automatic logic [29:0] cordic_atan(input logic [4:0] i);
      logic [29:0] a;
      case (i)
         5'd0:  a = 30'd843314856;
         5'd1:  a = 30'd497837829;
         5'd2:  a = 30'd263043836;
         5'd3:  a = 30'd133525158;
         5'd4:  a = 30'd67021686;
         5'd5:  a = 30'd33543515;
         5'd6:  a = 30'd16775850;
         5'd7:  a = 30'd8388437;
         5'd8:  a = 30'd4194282;
         5'd9:  a = 30'd2097149;
         5'd10: a = 30'd1048575;
         5'd11: a = 30'd524287;
         5'd12: a = 30'd262143;
         5'd13: a = 30'd131071;
         5'd14: a = 30'd65535;
         5'd15: a = 30'd32767;
         5'd16: a = 30'd16383;
         5'd17: a = 30'd8191;
         5'd18: a = 30'd4095;
         5'd19: a = 30'd2047;
         5'd20: a = 30'd1023;
         5'd21: a = 30'd511;
         5'd22: a = 30'd255;
         5'd23: a = 30'd127;
         5'd24: a = 30'd63;
         5'd25: a = 30'd31;
         5'd26: a = 30'd15;
         5'd27: a = 30'd8;
         5'd28: a = 30'd4;
         5'd29: a = 30'd2;
         5'd30: a = 30'd1;
         default: a = 30'd0;
      endcase
      return a;
   endfunction

   // sign of term t in row r of the quaternion product dq * q
   function automatic logic qp_neg(input logic [1:0] r, input logic [1:0] t);
      logic n;
      case (r)
         2'd0:    n = (t != 2'd0);
         2'd1:    n = (t == 2'd3);
         2'd2:    n = (t == 2'd1);
         default: n = (t == 2'd2);
      endcase
      return n;
   endfunction

endpackage

FILE: design/qemi_div.sv
// ----------------------------------------------------------------------------
// qemi_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qemi_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [qemi_pkg::DVD_W-1:0]    dividend,
   input  logic [qemi_pkg::DSR_W-1:0]    divisor,
   output logic                          done,
   output logic [qemi_pkg::DVD_W-1:0]    quotient
);
   import qemi_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [DSR_W-1:0]     dsr_ff, dsr_in;
   logic [DSR_W-1:0]     rem_ff, rem_in;
   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [DSR_W:0]       try_v;
   logic [DSR_W:0]       diff_v;
   logic                 ge;

   assign try_v  = {rem_ff, dvd_ff[DVD_W-1]};
   assign diff_v = try_v - {1'b0, dsr_ff};
   assign ge     = (try_v >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         rem_in = ge ? diff_v[DSR_W-1:0] : try_v[DSR_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: design/quaternion_exp_map_integrator_top.sv
// Throughput: one item at a time; req_tready is high only when the sequencer is idle.
// The 62-step shared divider computes four quotients for small angles and five otherwise;
// the 32-step square root runs once for small angles and twice otherwise.
// A finished item waits in the output register while the next item is accepted.
// Synchronous reset: orientation (1,0,0,0), initial registers (1,0,0,0), no item pending.
// ----------------------------------------------------------------------------
// quaternion_exp_map_integrator_top
// Integrates an orientation quaternion by the exponential map, one item per
// angular velocity sample, using one shared multiplier under a sequencer.
// ----------------------------------------------------------------------------
module quaternion_exp_map_integrator_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // ang_vel_x, ang_vel_y, ang_vel_z, time_step
   input  logic         req_tuser,   // restart
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // quat_w, quat_x, quat_y, quat_z
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   import qemi_pkg::*;

   typedef enum logic [17:0] {
      ST_IDLE   = 18'h00001,
      ST_VMUL   = 18'h00002,
      ST_VSAT   = 18'h00004,
      ST_VSQ    = 18'h00008,
      ST_VACC   = 18'h00010,
      ST_TEST   = 18'h00020,
      ST_SQRT   = 18'h00040,
      ST_CORDIC = 18'h00080,
      ST_DIVLD  = 18'h00100,
      ST_DIV    = 18'h00200,
      ST_DQMUL  = 18'h00400,
      ST_DQSTO  = 18'h00800,
      ST_QMUL   = 18'h01000,
      ST_QACC   = 18'h02000,
      ST_MAX    = 18'h04000,
      ST_NSHIFT = 18'h08000,
      ST_N2MUL  = 18'h10000,
      ST_N2ACC  = 18'h20000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0]  k_ff, k_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        norm_ph_ff, norm_ph_in;
   logic        done_ff, done_in;

   logic signed [31:0] w_ff [3];
   logic signed [31:0] w_in [3];
   logic [31:0]        dt_ff, dt_in;
   logic signed [31:0] bq_ff [4];
   logic signed [31:0] bq_in [4];
   logic signed [31:0] init_ff [4];
   logic signed [31:0] init_in [4];
   logic signed [31:0] v_ff [3];
   logic signed [31:0] v_in [3];
   logic [63:0]        tsq_ff, tsq_in;
   logic signed [67:0] prod_ff;
   logic [31:0]        theta_ff, theta_in;
   logic [31:0]        norm_ff, norm_in;
   logic [63:0]        sq_src_ff, sq_src_in;
   logic [33:0]        sq_rem_ff, sq_rem_in;
   logic [31:0]        sq_root_ff, sq_root_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [33:0] s_ff, s_in;
   logic signed [33:0] dq_ff [4];
   logic signed [33:0] dq_in [4];
   logic signed [37:0] p_ff [4];
   logic signed [37:0] p_in [4];
   logic [37:0]        mx_ff, mx_in;
   logic [63:0]        n2_ff, n2_in;
   logic signed [31:0] res_ff [4];
   logic signed [31:0] res_in [4];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [127:0]       rsp_data_ff, rsp_data_in;

   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_p;
   logic signed [67:0] vsh;
   logic signed [31:0] vsat;
   logic [34:0]        sq_try, sq_trial, sq_diff;
   logic               sq_ge;
   logic [31:0]        sq_root_nx;
   logic signed [33:0] cx, cy, cat;
   logic [1:0]         qr, qt, qb;
   logic signed [37:0] term, base;
   logic [37:0]        pabs [4];
   logic [37:0]        mxa, mxb, mxc;
   logic [63:0]        n2_sum;
   logic               div_start, div_done;
   logic [DVD_W-1:0]   div_dvd, div_quo;
   logic [DSR_W-1:0]   div_dsr;
   logic [33:0]        y_abs;
   logic [37:0]        pk_abs;

   qemi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .done     (div_done),
      .quotient (div_quo)
   );

   // shared multiplier
   assign qr = cnt_ff[3:2];
   assign qt = cnt_ff[1:0];
   assign qb = qr ^ qt;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_VMUL: begin
            mul_a = 34'(w_ff[k_ff]);
            mul_b = {2'b00, dt_ff};
         end
         ST_VSQ: begin
            mul_a = 34'(v_ff[k_ff]);
            mul_b = 34'(v_ff[k_ff]);
         end
         ST_DQMUL: begin
            mul_a = 34'(v_ff[k_ff]);
            mul_b = s_ff;
         end
         ST_QMUL: begin
            mul_a = dq_ff[qt];
            mul_b = 34'(bq_ff[qb]);
         end
         ST_N2MUL: begin
            mul_a = p_ff[k_ff][33:0];
            mul_b = p_ff[k_ff][33:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign vsh = prod_ff >>> 10;
   always_comb begin
      if (!vsh[67] && (|vsh[66:31]))
         vsat = 32'sh7FFFFFFF;
      else if (vsh[67] && !(&vsh[66:31]))
         vsat = 32'sh80000000;
      else
         vsat = vsh[31:0];
   end

   // square root, two radicand bits per step
   assign sq_try     = {sq_rem_ff[32:0], sq_src_ff[63:62]};
   assign sq_trial   = {1'b0, sq_root_ff, 2'b01};
   assign sq_ge      = (sq_try >= sq_trial);
   assign sq_diff    = sq_try - sq_trial;
   assign sq_root_nx = {sq_root_ff[30:0], sq_ge};

   assign cx  = y_ff >>> cnt_ff;
   assign cy  = x_ff >>> cnt_ff;
   assign cat = {4'b0000, cordic_atan(cnt_ff)};

   assign term = prod_ff[67:30];
   assign base = (qt == 2'd0) ? 38'sd0 : p_ff[qr];

   always_comb begin
      for (int i = 0; i < 4; i++)
         pabs[i] = p_ff[i][37] ? 38'(-p_ff[i]) : 38'(p_ff[i]);
      mxa = (pabs[1] > pabs[0]) ? pabs[1] : pabs[0];
      mxb = (pabs[3] > pabs[2]) ? pabs[3] : pabs[2];
      mxc = (mxb > mxa) ? mxb : mxa;
   end

   assign n2_sum = n2_ff + prod_ff[63:0];
   assign y_abs  = y_ff[33] ? 34'(-y_ff) : 34'(y_ff);
   assign pk_abs = p_ff[k_ff][37] ? 38'(-p_ff[k_ff]) : 38'(p_ff[k_ff]);

   assign div_start = (state_ff == ST_DIVLD);
   assign div_dvd   = norm_ph_ff ? {pk_abs[31:0], 30'd0} : {y_abs[31:0], 30'd0};
   assign div_dsr   = norm_ph_ff ? norm_ff : theta_ff;

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      norm_ph_in   = norm_ph_ff;
      done_in      = 1'b0;
      w_in         = w_ff;
      dt_in        = dt_ff;
      bq_in        = bq_ff;
      init_in      = init_ff;
      v_in         = v_ff;
      tsq_in       = tsq_ff;
      theta_in     = theta_ff;
      norm_in      = norm_ff;
      sq_src_in    = sq_src_ff;
      sq_rem_in    = sq_rem_ff;
      sq_root_in   = sq_root_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      s_in         = s_ff;
      dq_in        = dq_ff;
      p_in         = p_ff;
      mx_in        = mx_ff;
      n2_in        = n2_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_we)
         init_in[csr_index] = csr_wdata;

      if (rsp_valid_ff && rsp_tready)
         rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (done_ff && !rsp_valid_in) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_ff[3], res_ff[2], res_ff[1], res_ff[0]};
               bq_in        = res_ff;
            end else if (done_ff) begin
               done_in = 1'b1;
            end else if (req_tvalid) begin
               w_in[0] = req_tdata[31:0];
               w_in[1] = req_tdata[63:32];
               w_in[2] = req_tdata[95:64];
               dt_in   = req_tdata[127:96];
               if (req_tuser)
                  bq_in = init_ff;
               k_in       = '0;
               tsq_in     = '0;
               norm_ph_in = 1'b0;
               state_in   = ST_VMUL;
            end
         end
         ST_VMUL: state_in = ST_VSAT;
         ST_VSAT: begin
            v_in[k_ff] = vsat;
            state_in   = ST_VSQ;
         end
         ST_VSQ: state_in = ST_VACC;
         ST_VACC: begin
            tsq_in = tsq_ff + prod_ff[63:0];
            if (k_ff == 2'd2) begin
               state_in = ST_TEST;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_VMUL;
            end
         end
         ST_TEST: begin
            cnt_in = '0;
            if (tsq_ff < SMALL_ANGLE_LIM) begin
               dq_in[0] = ONE_Q30;
               for (int i = 0; i < 3; i++)
                  dq_in[i+1] = 34'(v_ff[i] >>> 1);
               state_in = ST_QMUL;
            end else begin
               sq_src_in  = tsq_ff;
               sq_rem_in  = '0;
               sq_root_in = '0;
               state_in   = ST_SQRT;
            end
         end
         ST_SQRT: begin
            sq_src_in  = {sq_src_ff[61:0], 2'b00};
            sq_rem_in  = sq_ge ? sq_diff[33:0] : sq_try[33:0];
            sq_root_in = sq_root_nx;
            cnt_in     = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               cnt_in = '0;
               if (norm_ph_ff) begin
                  norm_in  = sq_root_nx;
                  k_in     = '0;
                  state_in = ST_DIVLD;
               end else begin
                  theta_in = sq_root_nx;
                  x_in     = ONE_Q30;
                  y_in     = '0;
                  z_in     = {3'b000, sq_root_nx[31:1]};
                  state_in = ST_CORDIC;
               end
            end
         end
         ST_CORDIC: begin
            if (!z_ff[33]) begin
               x_in = x_ff - cx;
               y_in = y_ff + cy;
               z_in = z_ff - cat;
            end else begin
               x_in = x_ff + cx;
               y_in = y_ff - cy;
               z_in = z_ff + cat;
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(CORDIC_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_DIVLD;
            end
         end
         ST_DIVLD: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               if (!norm_ph_ff) begin
                  s_in     = y_ff[33] ? 34'(-div_quo[33:0]) : div_quo[33:0];
                  dq_in[0] = x_ff;
                  k_in     = '0;
                  state_in = ST_DQMUL;
               end else begin
                  res_in[k_ff] = p_ff[k_ff][37] ? 32'(-div_quo[31:0]) : div_quo[31:0];
                  if (k_ff == 2'd3) begin
                     done_in  = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     k_in     = k_ff + 2'd1;
                     state_in = ST_DIVLD;
                  end
               end
            end
         end
         ST_DQMUL: state_in = ST_DQSTO;
         ST_DQSTO: begin
            dq_in[k_ff + 2'd1] = prod_ff[63:30];
            if (k_ff == 2'd2) begin
               cnt_in   = '0;
               state_in = ST_QMUL;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_DQMUL;
            end
         end
         ST_QMUL: state_in = ST_QACC;
         ST_QACC: begin
            p_in[qr] = qp_neg(qr, qt) ? (base - term) : (base + term);
            cnt_in   = cnt_ff + 5'd1;
            if (cnt_ff[3:0] == 4'd15) begin
               cnt_in   = '0;
               state_in = ST_MAX;
            end else begin
               state_in = ST_QMUL;
            end
         end
         ST_MAX: begin
            mx_in = mxc;
            if (mxc == '0) begin
               res_in[0] = ONE_Q30[31:0];
               res_in[1] = '0;
               res_in[2] = '0;
               res_in[3] = '0;
               done_in   = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_NSHIFT;
            end
         end
         ST_NSHIFT: begin
            if (|mx_ff[37:31]) begin
               for (int i = 0; i < 4; i++)
                  p_in[i] = p_ff[i] >>> 1;
               mx_in = mx_ff >> 1;
            end else if (mx_ff[37:30] == '0) begin
               for (int i = 0; i < 4; i++)
                  p_in[i] = p_ff[i] <<< 1;
               mx_in = mx_ff << 1;
            end else begin
               k_in     = '0;
               n2_in    = '0;
               state_in = ST_N2MUL;
            end
         end
         ST_N2MUL: state_in = ST_N2ACC;
         ST_N2ACC: begin
            n2_in = n2_sum;
            if (k_ff == 2'd3) begin
               sq_src_in  = n2_sum;
               sq_rem_in  = '0;
               sq_root_in = '0;
               cnt_in     = '0;
               norm_ph_in = 1'b1;
               state_in   = ST_SQRT;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_N2MUL;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         cnt_ff       <= '0;
         norm_ph_ff   <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bq_ff[0]     <= ONE_Q30[31:0];
         bq_ff[1]     <= '0;
         bq_ff[2]     <= '0;
         bq_ff[3]     <= '0;
         init_ff[0]   <= ONE_Q30[31:0];
         init_ff[1]   <= '0;
         init_ff[2]   <= '0;
         init_ff[3]   <= '0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         cnt_ff       <= cnt_in;
         norm_ph_ff   <= norm_ph_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         bq_ff        <= bq_in;
         init_ff      <= init_in;
      end
      w_ff        <= w_in;
      dt_ff       <= dt_in;
      v_ff        <= v_in;
      tsq_ff      <= tsq_in;
      prod_ff     <= mul_p;
      theta_ff    <= theta_in;
      norm_ff     <= norm_in;
      sq_src_ff   <= sq_src_in;
      sq_rem_ff   <= sq_rem_in;
      sq_root_ff  <= sq_root_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      s_ff        <= s_in;
      dq_ff       <= dq_in;
      p_ff        <= p_in;
      mx_ff       <= mx_in;
      n2_ff       <= n2_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE) && !done_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
